>>> hw/rtl/pkthc_pkg.sv
`timescale 1ns / 1ps
// package for the packet header checksum checker
// types and constants shared by all rtl modules; no dependencies
package pkthc_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int HDR_STORE    = HEADER_BYTES - 1;
    localparam int HDR_IDX_W    = $clog2(HDR_STORE);
    localparam int POS_W        = 15;
    localparam int SUM_W        = 23;
    localparam int ACC_W        = 32;

    // checksum modulus, (1 << 23) - 1
    localparam logic [SUM_W-1:0] SUM_MODULUS = {SUM_W{1'b1}};

    typedef struct packed {
        logic [27:0] source_address;
        logic [27:0] destination_address;
        logic [3:0]  source_port;
        logic [3:0]  destination_port;
        logic [13:0] fragment_offset;
        logic [13:0] total_length;
        logic [4:0]  hop_limit;
        logic [22:0] checksum;
        logic [1:0]  compression_kind;
        logic [5:0]  traffic_kind;
        logic        length_bad;
    } hdr_fields_t;

    // one step of the running sum, from the parser to the accumulator
    typedef struct packed {
        logic             first;
        logic             last;
        logic [ACC_W-1:0] contrib;
        hdr_fields_t      fields;
    } pkt_evt_t;

    // finished packet, from the accumulator to the output stage
    typedef struct packed {
        logic [ACC_W-1:0] total;
        hdr_fields_t      fields;
    } pkt_sum_t;

endpackage

>>> hw/rtl/pkthc_byte_if.sv
`timescale 1ns / 1ps
// byte stream channel: valid, ready and one packet byte
// no dependencies
interface pkthc_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);

endinterface

>>> hw/rtl/pkthc_res_if.sv
`timescale 1ns / 1ps
// result channel: valid, ready and the decoded header with the checksum verdict
// no dependencies
interface pkthc_res_if;

    logic        valid;
    logic        ready;
    logic [27:0] source_address;
    logic [27:0] destination_address;
    logic [3:0]  source_port;
    logic [3:0]  destination_port;
    logic [13:0] fragment_offset;
    logic [13:0] total_length;
    logic [4:0]  hop_limit;
    logic [1:0]  compression_kind;
    logic [5:0]  traffic_kind;
    logic [22:0] computed_sum;
    logic        sum_matches;
    logic        length_bad;

    modport source (
        output valid, output source_address, output destination_address,
        output source_port, output destination_port, output fragment_offset,
        output total_length, output hop_limit, output compression_kind,
        output traffic_kind, output computed_sum, output sum_matches,
        output length_bad, input ready
    );
    modport sink (
        input valid, input source_address, input destination_address,
        input source_port, input destination_port, input fragment_offset,
        input total_length, input hop_limit, input compression_kind,
        input traffic_kind, input computed_sum, input sum_matches,
        input length_bad, output ready
    );

endinterface

>>> hw/rtl/packet_header_checksum_checker_core.sv
`timescale 1ns / 1ps
// Packet header checksum checker. Takes one packet byte per cycle on stream,
// header first, while input ready is high; after the 16-byte header it consumes
// the payload rounded up to whole 32-bit words and reports one item on report
// per packet: the decoded header fields, the sum of those fields but the
// checksum and the magnitudes of the payload words reduced modulo 2^23-1, a
// checksum match flag and a flag for a length field below 16 (payload then
// taken as empty). Bytes are accepted back to back across packet boundaries;
// the result shows on report once the last byte of its packet has passed the
// three-register pipeline (byte parser, running-sum adder, modulo reduction
// and output register). Input ready drops only while two finished results are
// waiting, one in the output register and one behind it in the running-sum
// stage, and the closing byte of a third packet has caught up with them.
// No clearing pass: the header store is always written before it is read.
module packet_header_checksum_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    pkthc_byte_if.sink  stream,
    pkthc_res_if.source report
);
    import pkthc_pkg::*;

    logic     evt_valid;
    pkt_evt_t evt;
    logic     evt_ready;
    logic     sum_valid;
    pkt_sum_t sum;
    logic     sum_ready;

    pkthc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_ready (evt_ready)
    );

    pkthc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_ready (evt_ready),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_ready (sum_ready)
    );

    pkthc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_ready (sum_ready),
        .report    (report)
    );

    // the reduced sum never reaches the modulus itself
    assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> (report.computed_sum != SUM_MODULUS))
    else $error("computed_sum not fully reduced");

    // a packet never opens and closes on the same byte
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> !(evt.first && evt.last))
    else $error("packet start and end on one byte");

    // every accepted byte shows up as a parser item in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready) |=> evt_valid)
    else $error("accepted byte lost in parser");

    // a finished total waiting for the output slot is neither dropped nor changed
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !sum_ready) |=> (sum_valid && $stable(sum)))
    else $error("pending packet total lost");

endmodule

>>> hw/rtl/pkthc_parse.sv
`timescale 1ns / 1ps
// byte parser: tracks position in the packet, stores and decodes the header,
// gathers payload words and registers one sum contribution per byte (pkthc_pkg)
module pkthc_parse (
    input  logic                clk,
    input  logic                rst_n,
    pkthc_byte_if.sink          stream,
    output logic                evt_valid,
    output pkthc_pkg::pkt_evt_t evt,
    input  logic                evt_ready
);
    import pkthc_pkg::*;

    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [23:0]      word_reg, word_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [7:0]       hdr_reg [HDR_STORE];
    hdr_fields_t      pkt_fields_reg, pkt_fields_next;
    logic             evt_valid_reg, evt_valid_next;
    pkt_evt_t         evt_reg, evt_next;

    logic             in_fire;
    logic             hdr_we;
    logic [7:0]       hb [HEADER_BYTES];
    hdr_fields_t      dec;
    logic [13:0]      len_adj;
    logic [13:0]      payload_len;
    logic [POS_W-1:0] hdr_end;
    logic [31:0]      word;
    logic [POS_W-1:0] pos_inc;

    // weight of each header byte in the sum of all fields but the checksum
    function automatic logic [ACC_W-1:0] hdr_contrib(
        input logic [3:0] idx,
        input logic [7:0] b
    );
        logic [ACC_W-1:0] c;
        unique case (idx)
            4'd0:    c = ACC_W'(b) << 20;
            4'd1:    c = ACC_W'(b) << 12;
            4'd2:    c = ACC_W'(b) << 4;
            4'd3:    c = ACC_W'(b[7:4]) + (ACC_W'(b[3:0]) << 24);
            4'd4:    c = ACC_W'(b) << 16;
            4'd5:    c = ACC_W'(b) << 8;
            4'd6:    c = ACC_W'(b);
            4'd7:    c = ACC_W'(b[7:4]) + ACC_W'(b[3:0]);
            4'd8:    c = ACC_W'(b) << 6;
            4'd9:    c = ACC_W'(b[7:2]) + (ACC_W'(b[1:0]) << 12);
            4'd10:   c = ACC_W'(b) << 4;
            4'd11:   c = ACC_W'(b[7:4]) + (ACC_W'(b[3:0]) << 1);
            4'd12:   c = ACC_W'(b[7]);
            4'd15:   c = ACC_W'(b[7:6]) + ACC_W'(b[5:0]);
            default: c = '0;
        endcase
        return c;
    endfunction

    assign stream.ready = !evt_valid_reg || evt_ready;
    assign in_fire      = stream.valid && stream.ready;
    assign hdr_we       = in_fire && (pos_reg < POS_HDR_LAST);
    assign evt_valid    = evt_valid_reg;
    assign evt          = evt_reg;

    // header view with the last byte taken straight from the input
    always_comb
    begin
        for (int i = 0; i < HDR_STORE; i++)
        begin
            hb[i] = hdr_reg[i];
        end
        hb[HEADER_BYTES-1] = stream.data_byte;
    end

    always_comb
    begin
        dec.source_address      = {hb[0], hb[1], hb[2], hb[3][7:4]};
        dec.destination_address = {hb[3][3:0], hb[4], hb[5], hb[6]};
        dec.source_port         = hb[7][7:4];
        dec.destination_port    = hb[7][3:0];
        dec.fragment_offset     = {hb[8], hb[9][7:2]};
        dec.total_length        = {hb[9][1:0], hb[10], hb[11][7:4]};
        dec.hop_limit           = {hb[11][3:0], hb[12][7]};
        dec.checksum            = {hb[12][6:0], hb[13], hb[14]};
        dec.compression_kind    = hb[15][7:6];
        dec.traffic_kind        = hb[15][5:0];
        dec.length_bad          = dec.total_length < 14'(HEADER_BYTES);
    end

    // payload rounded up to whole words, empty when the length is too small
    assign len_adj     = dec.total_length - 14'(HEADER_BYTES - 3);
    assign payload_len = dec.length_bad ? '0 : {len_adj[13:2], 2'b00};
    assign hdr_end     = POS_PAYLOAD + POS_W'(payload_len);
    assign word        = {word_reg, stream.data_byte};
    assign pos_inc     = pos_reg + POS_W'(1);

    always_comb
    begin
        pos_next        = pos_reg;
        word_next       = word_reg;
        end_next        = end_reg;
        pkt_fields_next = pkt_fields_reg;
        evt_valid_next  = evt_valid_reg;
        evt_next        = evt_reg;

        if (in_fire)
        begin
            evt_valid_next = 1'b1;
            evt_next.first = (pos_reg == '0);
            evt_next.last  = 1'b0;
            evt_next.contrib = '0;
            evt_next.fields  = pkt_fields_reg;
            if (pos_reg < POS_PAYLOAD)
            begin
                evt_next.contrib = hdr_contrib(pos_reg[3:0], stream.data_byte);
                if (pos_reg == POS_HDR_LAST)
                begin
                    end_next        = hdr_end;
                    word_next       = '0;
                    pkt_fields_next = dec;
                    evt_next.fields = dec;
                    if (payload_len == '0)
                    begin
                        evt_next.last = 1'b1;
                        pos_next      = '0;
                    end
                    else
                    begin
                        pos_next = POS_PAYLOAD;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            else
            begin
                if (pos_reg[1:0] == 2'b11)
                begin
                    // magnitude of the signed word; the most negative one stays 2^31
                    evt_next.contrib = word[31] ? (~word + 32'd1) : word;
                    word_next        = '0;
                end
                else
                begin
                    word_next = {word_reg[15:0], stream.data_byte};
                end
                if (pos_inc >= end_reg)
                begin
                    evt_next.last = 1'b1;
                    pos_next      = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end
        else if (evt_valid_reg && evt_ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            word_reg      <= '0;
            end_reg       <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            word_reg      <= word_next;
            end_reg       <= end_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_fields_reg <= pkt_fields_next;
        evt_reg        <= evt_next;
        if (hdr_we)
        begin
            hdr_reg[pos_reg[HDR_IDX_W-1:0]] <= stream.data_byte;
        end
    end

endmodule

>>> hw/rtl/pkthc_accum.sv
`timescale 1ns / 1ps
// running sum: adds one contribution per item and hands the finished
// packet total to the output stage (pkthc_pkg)
module pkthc_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    input  pkthc_pkg::pkt_evt_t evt,
    output logic                evt_ready,
    output logic                sum_valid,
    output pkthc_pkg::pkt_sum_t sum,
    input  logic                sum_ready
);
    import pkthc_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             sum_valid_reg;
    pkt_sum_t         sum_reg;
    logic             sum_free;
    logic             take;

    // only the closing item of a packet has to wait for the output slot
    assign sum_free  = !sum_valid_reg || sum_ready;
    assign evt_ready = !evt.last || sum_free;
    assign take      = evt_valid && evt_ready;
    assign acc_next  = evt.first ? evt.contrib : acc_reg + evt.contrib;
    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_free)
        begin
            sum_valid_reg <= take && evt.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            acc_reg <= acc_next;
        end
        if (take && evt.last)
        begin
            sum_reg.total  <= acc_next;
            sum_reg.fields <= evt.fields;
        end
    end

endmodule

>>> hw/rtl/pkthc_out.sv
`timescale 1ns / 1ps
// output register: reduces the packet total modulo 2^23-1, compares it
// against the header checksum and holds the result item (pkthc_pkg, pkthc_res_if)
module pkthc_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    input  pkthc_pkg::pkt_sum_t sum,
    output logic                sum_ready,
    pkthc_res_if.source         report
);
    import pkthc_pkg::*;

    logic              valid_reg;
    hdr_fields_t       fields_reg;
    logic [SUM_W-1:0]  computed_reg;
    logic              match_reg;
    logic [SUM_W:0]    folded;
    logic [SUM_W-1:0]  reduced;
    logic              load;

    assign sum_ready = !valid_reg || report.ready;
    assign load      = sum_valid && sum_ready;

    // 2^23 is 1 modulo 2^23-1, so fold the top bits down, then one subtract
    assign folded  = {1'b0, sum.total[SUM_W-1:0]} + (SUM_W+1)'(sum.total[ACC_W-1:SUM_W]);
    assign reduced = (folded >= {1'b0, SUM_MODULUS}) ?
                     SUM_W'(folded - {1'b0, SUM_MODULUS}) : folded[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fields_reg   <= sum.fields;
            computed_reg <= reduced;
            match_reg    <= (reduced == sum.fields.checksum);
        end
    end

    assign report.valid               = valid_reg;
    assign report.source_address      = fields_reg.source_address;
    assign report.destination_address = fields_reg.destination_address;
    assign report.source_port         = fields_reg.source_port;
    assign report.destination_port    = fields_reg.destination_port;
    assign report.fragment_offset     = fields_reg.fragment_offset;
    assign report.total_length        = fields_reg.total_length;
    assign report.hop_limit           = fields_reg.hop_limit;
    assign report.compression_kind    = fields_reg.compression_kind;
    assign report.traffic_kind        = fields_reg.traffic_kind;
    assign report.computed_sum        = computed_reg;
    assign report.sum_matches         = match_reg;
    assign report.length_bad          = fields_reg.length_bad;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// testbench for packet_header_checksum_checker_core: directed and random packets, checked per field
// depends on pkthc_pkg, pkthc_byte_if, pkthc_res_if and the core rtl
module tb;
    import pkthc_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 300;

    typedef enum int {PK_SHAPED, PK_NOISE, PK_SHORT} pkt_kind_e;

    // header as it travels on the wire, byte 0 in the top bits
    typedef struct packed {
        logic [27:0] orig_addr;
        logic [27:0] dst_addr;
        logic [3:0]  orig_port;
        logic [3:0]  dst_port;
        logic [13:0] frag;
        logic [13:0] len;
        logic [4:0]  hops;
        logic [22:0] check;
        logic [1:0]  comp;
        logic [5:0]  traffic;
    } hdr_layout_t;

    typedef struct packed {
        logic [27:0] source_address;
        logic [27:0] destination_address;
        logic [3:0]  source_port;
        logic [3:0]  destination_port;
        logic [13:0] fragment_offset;
        logic [13:0] total_length;
        logic [4:0]  hop_limit;
        logic [1:0]  compression_kind;
        logic [5:0]  traffic_kind;
        logic [22:0] computed_sum;
        logic        sum_matches;
        logic        length_bad;
    } report_t;

    typedef struct packed {
        logic    typed;
        report_t want;
    } table_answer_t;

    typedef struct packed {
        hdr_layout_t   hdr;
        logic [1:0]    n_words;
        logic [63:0]   words;
        table_answer_t answer;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pkthc_byte_if stream ();
    pkthc_res_if  report ();

    packet_header_checksum_checker_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .report (report)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // packet tracker state
    logic [14:0]  pos_in_pkt = '0;
    logic [127:0] hdr_shift  = '0;
    logic [23:0]  word_part  = '0;
    logic [31:0]  pkt_sum    = '0;
    logic [14:0]  pkt_end    = '0;

    report_t       awaited_reports [$];
    table_answer_t table_answers [$];

    int errors        = 0;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    bit hold_go       = 1'b0;

    function automatic logic [31:0] field_total(hdr_layout_t h);
        return 32'(h.orig_addr) + 32'(h.dst_addr) + 32'(h.orig_port) + 32'(h.dst_port)
             + 32'(h.frag) + 32'(h.len) + 32'(h.hops) + 32'(h.comp) + 32'(h.traffic);
    endfunction

    // most negative word wraps back onto itself, i.e. counts as 2^31
    function automatic logic [31:0] magnitude(logic [31:0] w);
        return w[31] ? 32'd0 - w : w;
    endfunction

    function automatic logic [SUM_W-1:0] fold_sum(logic [31:0] s);
        logic [31:0] m;
        m = s % 32'(SUM_MODULUS);
        return m[SUM_W-1:0];
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        hdr_layout_t   h;
        report_t       r;
        table_answer_t t;
        logic          done;
        done = 1'b0;
        if (pos_in_pkt < 15'(HEADER_BYTES))
        begin
            hdr_shift  = {hdr_shift[119:0], b};
            pos_in_pkt = pos_in_pkt + 15'd1;
            if (pos_in_pkt == 15'(HEADER_BYTES))
            begin
                h       = hdr_shift;
                pkt_end = 15'(HEADER_BYTES);
                // payload rounded up to whole words; short length means no payload
                if (h.len >= 14'(HEADER_BYTES))
                    pkt_end = pkt_end + ((15'(h.len) - 15'(HEADER_BYTES) + 15'd3) & ~15'd3);
                pkt_sum   = field_total(h);
                word_part = '0;
                done      = (pkt_end == 15'(HEADER_BYTES));
            end
        end
        else
        begin
            if (pos_in_pkt[1:0] != 2'd3)
                word_part = {word_part[15:0], b};
            else
            begin
                pkt_sum   = pkt_sum + magnitude({word_part, b});
                word_part = '0;
            end
            pos_in_pkt = pos_in_pkt + 15'd1;
            done       = (pos_in_pkt >= pkt_end);
        end
        if (done)
        begin
            pos_in_pkt            = '0;
            h                     = hdr_shift;
            r.source_address      = h.orig_addr;
            r.destination_address = h.dst_addr;
            r.source_port         = h.orig_port;
            r.destination_port    = h.dst_port;
            r.fragment_offset     = h.frag;
            r.total_length        = h.len;
            r.hop_limit           = h.hops;
            r.compression_kind    = h.comp;
            r.traffic_kind        = h.traffic;
            r.computed_sum        = fold_sum(pkt_sum);
            r.sum_matches         = (r.computed_sum == h.check);
            r.length_bad          = (h.len < 14'(HEADER_BYTES));
            if (table_answers.size() > 0)
            begin
                t = table_answers.pop_front();
                if (t.typed)
                    r = t.want;
            end
            awaited_reports.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t tb: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // results are checked before the same edge's byte is absorbed
    always @(posedge clk)
    begin : watch
        report_t want;
        if (rst_n && report.valid && report.ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t tb: result with nothing awaited, expected none, actual sum %0h",
                         $time, report.computed_sum);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("source_address", 32'(want.source_address),
                            32'(report.source_address));
                check_field("destination_address", 32'(want.destination_address),
                            32'(report.destination_address));
                check_field("source_port", 32'(want.source_port), 32'(report.source_port));
                check_field("destination_port", 32'(want.destination_port),
                            32'(report.destination_port));
                check_field("fragment_offset", 32'(want.fragment_offset),
                            32'(report.fragment_offset));
                check_field("total_length", 32'(want.total_length), 32'(report.total_length));
                check_field("hop_limit", 32'(want.hop_limit), 32'(report.hop_limit));
                check_field("compression_kind", 32'(want.compression_kind),
                            32'(report.compression_kind));
                check_field("traffic_kind", 32'(want.traffic_kind), 32'(report.traffic_kind));
                check_field("computed_sum", 32'(want.computed_sum), 32'(report.computed_sum));
                check_field("sum_matches", 32'(want.sum_matches), 32'(report.sum_matches));
                check_field("length_bad", 32'(want.length_bad), 32'(report.length_bad));
            end
        end
        if (rst_n && stream.valid && stream.ready)
            absorb_byte(stream.data_byte);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        report.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                report.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                report.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stream.valid <= 1'b0;
            @(posedge clk);
        end
        stream.valid     <= 1'b1;
        stream.data_byte <= b;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(hdr_layout_t h, logic [31:0] body [$]);
        logic [127:0] flat;
        flat = h;
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(flat[127 - 8*i -: 8]);
        foreach (body[k])
            for (int j = 3; j >= 0; j--)
                send_byte(body[k][8*j +: 8]);
    endtask

    task automatic send_random_packet(pkt_kind_e kind);
        hdr_layout_t h;
        logic [31:0] body [$];
        logic [31:0] w;
        logic [31:0] total;
        int          n_words;
        h = hdr_layout_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        case (kind)
            PK_SHAPED:
                case ($urandom_range(9))
                    0:       h.len = 14'($urandom_range(15));
                    1:       h.len = 14'd16;
                    2:       h.len = 14'($urandom_range(120, 49));
                    default: h.len = 14'($urandom_range(48, 17));
                endcase
            PK_NOISE:   h.len[13:9] = '0;
            PK_SHORT:   h.len = $urandom_range(1) ? 14'd16 : 14'($urandom_range(15));
            default:    h.len = 14'd16;
        endcase
        n_words = (h.len >= 14'(HEADER_BYTES)) ? (int'(h.len) - HEADER_BYTES + 3) / 4 : 0;
        total   = field_total(h);
        for (int i = 0; i < n_words; i++)
        begin
            case ($urandom_range(15))
                0:       w = 32'h8000_0000;
                1:       w = 32'h7FFF_FFFF;
                2:       w = 32'hFFFF_FFFF;
                3:       w = 32'h0000_0000;
                default: w = $urandom();
            endcase
            total = total + magnitude(w);
            body.push_back(w);
        end
        // half of the well-formed packets carry a matching checksum
        if (kind != PK_NOISE && $urandom_range(1) == 1)
            h.check = fold_sum(total);
        send_packet(h, body);
    endtask

    initial
    begin
        dir_row_t    dir_tab [5];
        logic [31:0] body [$];
        int          target;

        stream.valid     = 1'b0;
        stream.data_byte = '0;
        rst_n            = 1'b0;

        // all zero header: length too short, zero sum matches zero checksum
        dir_tab[0] = '{hdr: '0, n_words: 2'd0, words: '0,
                       answer: '{typed: 1'b1,
                                 want: '{sum_matches: 1'b1, length_bad: 1'b1, default: '0}}};
        // every field but the length at its top value, length 16 so empty payload, checksum out of reach
        dir_tab[1] = '{hdr: '{orig_addr: '1, dst_addr: '1, orig_port: '1, dst_port: '1,
                              frag: '1, len: 14'd16, hops: '1, check: '1, comp: '1,
                              traffic: '1},
                       n_words: 2'd0, words: '0, answer: '0};
        // largest short length
        dir_tab[2] = '{hdr: '{len: 14'd15, check: 23'd15, default: '0},
                       n_words: 2'd0, words: '0,
                       answer: '{typed: 1'b1,
                                 want: '{total_length: 14'd15, computed_sum: 23'd15,
                                         sum_matches: 1'b1, length_bad: 1'b1,
                                         default: '0}}};
        // most negative word and minus one
        dir_tab[3] = '{hdr: '{len: 14'd24, check: 23'd281, default: '0},
                       n_words: 2'd2, words: {32'h8000_0000, 32'hFFFF_FFFF}, answer: '0};
        // length not a multiple of four, pad bytes consumed
        dir_tab[4] = '{hdr: '{len: 14'd17, check: 23'd272, default: '0},
                       n_words: 2'd1, words: {32'h7FFF_FFFF, 32'h0}, answer: '0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 69;
        foreach (dir_tab[r])
        begin
            body.delete();
            for (int k = 0; k < dir_tab[r].n_words; k++)
                body.push_back(dir_tab[r].words[63 - 32*k -: 32]);
            table_answers.push_back(dir_tab[r].answer);
            send_packet(dir_tab[r].hdr, body);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 16 : 0;
            if (phase == 2)
            begin
                // short packets against a stalled result side back up the input
                hold_go = 1'b1;
                repeat (12) send_random_packet(PK_SHORT);
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                case ($urandom_range(19))
                    0:       send_random_packet(PK_NOISE);
                    1, 2:    send_random_packet(PK_SHORT);
                    default: send_random_packet(PK_SHAPED);
                endcase
            end
            if (phase == 0)
            begin
                // drain everything before going on
                stream.valid <= 1'b0;
                do
                    @(posedge clk);
                while (awaited_reports.size() > 0);
            end
        end

        stream.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_reports.size() > 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pkthc_pkg.sv
hw/rtl/pkthc_byte_if.sv
hw/rtl/pkthc_res_if.sv
hw/rtl/pkthc_parse.sv
hw/rtl/pkthc_accum.sv
hw/rtl/pkthc_out.sv
hw/rtl/packet_header_checksum_checker_core.sv
tb/tb.sv
